>>> hw/rtl/dqs_pkg.sv
// Shared types, constants and the sine table generator for the quadrature DDS core.
// Used by every module of the core; depends on nothing else.
package dqs_pkg;

   // Default sizes handed down as top-level parameters.
   localparam int TABLE_BITS_DEF  = 12;
   localparam int PHASE_BITS_DEF  = 16;
   localparam int NOISE_DEPTH_DEF = 16;

   // Field and register widths.
   localparam int SAMPLE_W   = 12;
   localparam int CODE_W     = 12;
   localparam int STEP_W     = 13;
   localparam int GAIN_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Register reset values.
   localparam logic [STEP_W-1:0] STEP_RESET = 13'd262;
   localparam logic [GAIN_W-1:0] AMP_RESET  = 8'd150;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd0;

   // Converter mid-scale and full scale.
   localparam int MID_CODE = 2048;
   localparam int MAX_CODE = 4095;

   // Input item queue depth between the front and back parts.
   localparam int QUEUE_DEPTH = 4;

   // Sine peak held in the table.
   localparam logic [63:0] PEAK   = 64'd1850;
   localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
   localparam logic [63:0] LOW32  = 64'h0000_0000_FFFF_FFFF;

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP = 2'd0,
      CSR_AMPLITUDE  = 2'd1,
      CSR_NOISE_GAIN = 2'd2
   } csr_index_type;

   // Operation codes carried in tuser.
   typedef enum logic {
      OP_TICK   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      logic [STEP_W-1:0] phase_step;
      logic [GAIN_W-1:0] amplitude;
      logic [GAIN_W-1:0] noise_gain;
   } cfg_type;

   typedef struct packed {
      op_type              op;
      logic [SAMPLE_W-1:0] value;
   } item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SIN,
      B_COS,
      B_MUL_S,
      B_MUL_C,
      B_SUM
   } back_state_type;

   // (a*b) >> 62 on unsigned Q62 values, evaluated at elaboration only.
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah, al, bh, bl, lo, m1, m2, hi, t;
      ah = a >> 32;
      al = a & LOW32;
      bh = b >> 32;
      bl = b & LOW32;
      lo = al * bl;
      m1 = ah * bl;
      m2 = al * bh;
      hi = ah * bh;
      t  = (lo >> 32) + (m1 & LOW32) + (m2 & LOW32);
      hi = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
      return (hi << 2) | ((t & LOW32) >> 30);
   endfunction

   // Truncated PEAK*sin(pi*j/2^(table_bits-1)) for j in the first quarter, by a
   // fixed-point Taylor series. Only used to build constant tables.
   function automatic logic signed [CODE_W-1:0] rom_value(input int j, input int table_bits);
      logic [63:0] x, x2, term, sum, res, prod;
      if (j == 0) begin
         return '0;
      end
      if (j >= (1 << (table_bits - 2))) begin
         return CODE_W'(PEAK);
      end
      x    = (PI_Q62 >> (table_bits - 1)) * 64'(j);
      x2   = q62_mul(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 13; n++) begin
         prod = q62_mul(term, x2);
         // Each term divides by (2n)(2n+1).
         case (n)
            1:  term = prod / 64'd6;
            2:  term = prod / 64'd20;
            3:  term = prod / 64'd42;
            4:  term = prod / 64'd72;
            5:  term = prod / 64'd110;
            6:  term = prod / 64'd156;
            7:  term = prod / 64'd210;
            8:  term = prod / 64'd272;
            9:  term = prod / 64'd342;
            10: term = prod / 64'd420;
            11: term = prod / 64'd506;
            12: term = prod / 64'd600;
            default: term = prod / 64'd702;
         endcase
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      res = (PEAK * (sum >> 32) + ((PEAK * (sum & LOW32)) >> 32)) >> 30;
      return CODE_W'(res);
   endfunction

endpackage

>>> hw/rtl/dqs_sine_rom.sv
// Quarter-wave sine table with a registered read port for the quadrature DDS core.
// Depends on dqs_pkg for the table generator.
module dqs_sine_rom #(
   parameter int TableBits = dqs_pkg::TABLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic [TableBits-1:0]               rd_addr,
   output logic signed [dqs_pkg::CODE_W-1:0]  rd_data
);

   localparam int QSize = 1 << (TableBits - 2);

   typedef logic signed [dqs_pkg::CODE_W-1:0] qtab_type [QSize+1];

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int j = 0; j <= QSize; j++) begin
         t[j] = dqs_pkg::rom_value(j, TableBits);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   logic [1:0]                         quadrant;
   logic [TableBits-3:0]               low;
   logic [TableBits-2:0]               qaddr;
   logic signed [dqs_pkg::CODE_W-1:0]  mag;
   logic signed [dqs_pkg::CODE_W-1:0]  rd_data_ff;
   logic signed [dqs_pkg::CODE_W-1:0]  rd_data_in;

   // The second and fourth quarters run the table backwards; the lower half is negated.
   always_comb begin
      quadrant = rd_addr[TableBits-1 -: 2];
      low      = rd_addr[TableBits-3:0];
      if (quadrant[0]) begin
         qaddr = (TableBits-1)'(QSize) - {1'b0, low};
      end else begin
         qaddr = {1'b0, low};
      end
      mag = QTAB[qaddr];
      rd_data_in = quadrant[1] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/dqs_front.sv
// Input side of the quadrature DDS core: accepts request beats, tags each as a tick or a
// noise sample and holds it in a short queue for the back end. Depends on dqs_pkg.
module dqs_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dqs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   output logic                               item_valid,
   output dqs_pkg::item_type                  item,
   input  logic                               item_pop
);

   localparam int PtrW = $clog2(dqs_pkg::QUEUE_DEPTH);

   dqs_pkg::item_type       queue_ff [dqs_pkg::QUEUE_DEPTH];
   dqs_pkg::item_type       entry_in;
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]           count_ff, count_in;
   logic                    push;

   assign req_tready = (count_ff != (PtrW+1)'(dqs_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      entry_in.op    = (req_tuser == dqs_pkg::OP_SAMPLE) ? dqs_pkg::OP_SAMPLE : dqs_pkg::OP_TICK;
      entry_in.value = req_tdata[dqs_pkg::SAMPLE_W-1:0];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

>>> hw/rtl/dqs_back.sv
// Execution side of the quadrature DDS core: noise ring with running sum, phase
// accumulator, table lookups, scaling and the result register. Depends on dqs_pkg
// and dqs_sine_rom.
module dqs_back #(
   parameter int TableBits  = dqs_pkg::TABLE_BITS_DEF,
   parameter int PhaseBits  = dqs_pkg::PHASE_BITS_DEF,
   parameter int NoiseDepth = dqs_pkg::NOISE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dqs_pkg::cfg_type                   cfg,
   input  logic                               item_valid,
   input  dqs_pkg::item_type                  item,
   output logic                               item_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dqs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int SlotW   = $clog2(NoiseDepth);
   localparam int SumW    = $clog2(NoiseDepth * dqs_pkg::MAX_CODE + 1);
   localparam int Centre  = NoiseDepth * dqs_pkg::MID_CODE;
   localparam int MagW    = $clog2(Centre + 1);
   localparam int Recip   = (1 << MagW) / NoiseDepth;
   localparam int AddW    = ((PhaseBits > dqs_pkg::STEP_W) ? PhaseBits : dqs_pkg::STEP_W) + 1;
   localparam int Quarter = 1 << (TableBits - 2);
   localparam int CW      = dqs_pkg::CODE_W;

   dqs_pkg::back_state_type state_ff, state_in;

   // Noise ring and its running sum.
   logic [dqs_pkg::SAMPLE_W-1:0] ring_ff [NoiseDepth];
   logic [SlotW-1:0]             slot_ff, slot_in;
   logic [SumW-1:0]              sum_ff, sum_in;

   logic [PhaseBits-1:0]         phase_ff;
   logic [AddW-1:0]              phase_sum;
   logic [TableBits-1:0]         idx;
   logic [TableBits-1:0]         rom_addr;
   logic signed [CW-1:0]         rom_data;

   logic                         neg_ff;
   logic [MagW-1:0]              mag_ff, mag_in;
   logic [2*MagW-1:0]            qprod;
   logic [CW-1:0]                qest_ff;
   logic [MagW-1:0]              qd;
   logic [MagW-1:0]              rem;
   logic [CW-1:0]                quot;
   logic signed [CW:0]           noise_ff;
   logic signed [CW-1:0]         sin_ff, cos_ff;
   logic signed [20:0]           prod_s_ff, prod_c_ff;
   logic signed [21:0]           prod_n_ff;

   logic signed [15:0]           term_s, term_c, term_n, sine_raw, cos_raw;
   logic [CW-1:0]                sine_code, cos_code;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dqs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Control outputs of the sequencer.
   logic                         ring_write, phase_load, rsp_load, out_free;

   // Product over 256, rounded toward zero.
   function automatic logic signed [15:0] div256(input logic signed [23:0] x);
      logic signed [23:0] t;
      t = x + (x[23] ? 24'sd255 : 24'sd0);
      return 16'(t >>> 8);
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dqs_pkg::B_IDLE: begin
            if (item_valid && item.op == dqs_pkg::OP_TICK) begin
               state_in = dqs_pkg::B_SIN;
            end
         end
         dqs_pkg::B_SIN:   state_in = dqs_pkg::B_COS;
         dqs_pkg::B_COS:   state_in = dqs_pkg::B_MUL_S;
         dqs_pkg::B_MUL_S: state_in = dqs_pkg::B_MUL_C;
         dqs_pkg::B_MUL_C: state_in = dqs_pkg::B_SUM;
         dqs_pkg::B_SUM: begin
            if (out_free) begin
               state_in = dqs_pkg::B_IDLE;
            end
         end
         default: state_in = dqs_pkg::B_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      item_pop   = 1'b0;
      ring_write = 1'b0;
      phase_load = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         dqs_pkg::B_IDLE: begin
            item_pop   = item_valid;
            ring_write = item_valid && item.op == dqs_pkg::OP_SAMPLE;
            phase_load = item_valid && item.op == dqs_pkg::OP_TICK;
         end
         dqs_pkg::B_SUM: rsp_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqs_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Ring write keeps the sum current, so a tick needs no pass over the ring.
   always_comb begin
      slot_in = (slot_ff == SlotW'(NoiseDepth - 1)) ? '0 : slot_ff + 1'b1;
      sum_in  = sum_ff - SumW'(ring_ff[slot_ff]) + SumW'(item.value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NoiseDepth; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff <= '0;
         sum_ff  <= '0;
      end else if (ring_write) begin
         ring_ff[slot_ff] <= item.value;
         slot_ff          <= slot_in;
         sum_ff           <= sum_in;
      end
   end

   assign phase_sum = AddW'(phase_ff) + AddW'(cfg.phase_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhaseBits'(1 << TableBits);
      end else if (phase_load) begin
         phase_ff <= phase_sum[PhaseBits-1:0];
      end
   end

   assign idx      = phase_ff[PhaseBits-1 -: TableBits];
   assign rom_addr = (state_ff == dqs_pkg::B_COS) ? idx + TableBits'(Quarter) : idx;

   dqs_sine_rom #(
      .TableBits (TableBits)
   ) u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // Centred noise mean: magnitude times a reciprocal, then one correction step.
   always_comb begin
      if (sum_ff >= SumW'(Centre)) begin
         mag_in = MagW'(sum_ff - SumW'(Centre));
      end else begin
         mag_in = MagW'(SumW'(Centre) - sum_ff);
      end
      qprod = (2*MagW)'(mag_ff) * (2*MagW)'(Recip);
      qd    = MagW'(qest_ff) * MagW'(NoiseDepth);
      rem   = mag_ff - qd;
      quot  = (rem >= MagW'(NoiseDepth)) ? qest_ff + 1'b1 : qest_ff;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         dqs_pkg::B_IDLE: begin
            mag_ff <= mag_in;
            neg_ff <= (sum_ff < SumW'(Centre));
         end
         dqs_pkg::B_SIN: begin
            qest_ff <= qprod[MagW +: CW];
         end
         dqs_pkg::B_COS: begin
            sin_ff   <= rom_data;
            noise_ff <= neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
         end
         dqs_pkg::B_MUL_S: begin
            cos_ff    <= rom_data;
            prod_s_ff <= $signed({1'b0, cfg.amplitude}) * sin_ff;
         end
         dqs_pkg::B_MUL_C: begin
            prod_c_ff <= $signed({1'b0, cfg.amplitude}) * cos_ff;
            prod_n_ff <= $signed({1'b0, cfg.noise_gain}) * noise_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      term_s   = div256(24'(prod_s_ff));
      term_c   = div256(24'(prod_c_ff));
      term_n   = div256(24'(prod_n_ff));
      sine_raw = term_s + 16'sd2048 + term_n;
      cos_raw  = term_c + 16'sd2048;
      if (sine_raw > 16'sd4095) begin
         sine_code = CW'(dqs_pkg::MAX_CODE);
      end else if (sine_raw < 16'sd0) begin
         sine_code = '0;
      end else begin
         sine_code = sine_raw[CW-1:0];
      end
      cos_code = cos_raw[CW-1:0];
   end

   // Result register: a finished beat waits here while the next item is taken.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {cos_code, sine_code};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/dds_quadrature_sine_with_noise_core.sv
// Top level of the quadrature DDS core with added noise: configuration registers and
// the front and back parts. Depends on dqs_pkg, dqs_front and dqs_back.
//
// Usage. Request beats arrive on req_*: tuser selects the kind of beat, 0 for a
// sample tick and 1 for a new random noise value, carried in tdata[11:0]. A noise
// beat only refills the noise ring and gives no response. A tick beat advances the
// phase accumulator and gives one response beat on rsp_*, with the clamped noisy
// sine in tdata[11:0] and the cosine in tdata[23:12].
// The csr_* channel writes phase step, amplitude and noise gain by index; it is always
// ready and should only be used while no tick is in flight.
// Sequencing. A queue of four beats sits in front of the sequencer. A noise beat is
// handled in the idle state alone; a tick is taken in the idle state and then passes
// through B_SIN, B_COS, B_MUL_S, B_MUL_C and B_SUM, set by the single registered table
// read port (sine, then cosine) and the scaling multiplies; B_SUM loads the response.
// Stalls. A finished response waits in the output register while the sequencer takes
// the next beat from the queue; a tick stalls only if that register is still full.
// Reset clears the queue, the noise ring and its running sum, sets the phase to one
// table length and loads the register defaults.
module dds_quadrature_sine_with_noise_core #(
   parameter int TableBits  = dqs_pkg::TABLE_BITS_DEF,
   parameter int PhaseBits  = dqs_pkg::PHASE_BITS_DEF,
   parameter int NoiseDepth = dqs_pkg::NOISE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dqs_pkg::REQ_DATA_W-1:0]     req_tdata,   // random_value[11:0], zero pad
   input  logic                               req_tuser,   // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dqs_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // noisy_sine, quadrature_cosine
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dqs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dqs_pkg::CSR_DATA_W-1:0]     csr_data
);

   dqs_pkg::cfg_type  cfg_ff, cfg_in;
   dqs_pkg::item_type item;
   logic              item_valid;
   logic              item_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dqs_pkg::CSR_PHASE_STEP: cfg_in.phase_step = csr_data[dqs_pkg::STEP_W-1:0];
            dqs_pkg::CSR_AMPLITUDE:  cfg_in.amplitude  = csr_data[dqs_pkg::GAIN_W-1:0];
            dqs_pkg::CSR_NOISE_GAIN: cfg_in.noise_gain = csr_data[dqs_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step <= dqs_pkg::STEP_RESET;
         cfg_ff.amplitude  <= dqs_pkg::AMP_RESET;
         cfg_ff.noise_gain <= dqs_pkg::GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dqs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   dqs_back #(
      .TableBits  (TableBits),
      .PhaseBits  (PhaseBits),
      .NoiseDepth (NoiseDepth)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
